// ----- rtl/fbsc_pkg.sv -----
// Shared constants, types and the class base size function of the size-class bitmap.
`timescale 1ns / 1ps

package fbsc_pkg;

    localparam int MIN_BLOCK    = 16;
    localparam int SMALL_POW2   = 8;
    localparam int BUCKET_POW2  = 2;
    localparam int SIZE_OCTAVES = 16;
    localparam int CLASS_WORDS  = 4;

    localparam int SIZE_W     = 24;
    localparam int CLS_W      = 7;
    localparam int POS_W      = $clog2(SIZE_W);
    localparam int CLS_WIDE_W = 12;

    localparam int SMALL_COUNT = ((2 ** SMALL_POW2) > MIN_BLOCK) ?
                                 ((2 ** SMALL_POW2) - MIN_BLOCK) / 4 : 0;
    localparam int CLASS_LIMIT = ((CLASS_WORDS * 32) < 128) ? (CLASS_WORDS * 32) : 128;
    localparam int LIM_WORDS   = CLASS_LIMIT / 32;
    localparam int WIDX_W      = (LIM_WORDS > 1) ? $clog2(LIM_WORDS) : 1;
    localparam int MAX_POW     = SMALL_POW2 + SIZE_OCTAVES;
    localparam int BKT_MASK    = (1 << BUCKET_POW2) - 1;

    typedef enum logic [1:0] {
        OP_MARK_SET = 2'd0,
        OP_MARK_CLR = 2'd1,
        OP_SEARCH   = 2'd2,
        OP_LARGEST  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_EXEC,
        ST_SCAN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load_in;
        logic do_map;
        logic do_exec;
        logic do_scan;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic err;
        logic found;
        logic last;
        logic out_free;
    } t_sts;

    // Smallest block size that falls into class c, low 24 bits.
    function automatic logic [SIZE_W-1:0] class_base(input logic [CLS_W-1:0] c);
        int          rel;
        int          oct;
        int          j;
        logic [47:0] base;
        logic [47:0] step;
        logic [47:0] sum;
        if (int'(c) < SMALL_COUNT) begin
            return SIZE_W'(int'(c) * 4 + MIN_BLOCK);
        end
        rel = int'(c) - SMALL_COUNT;
        oct = rel >> BUCKET_POW2;
        j   = rel & BKT_MASK;
        if (oct + SMALL_POW2 > 40) begin
            oct = 40 - SMALL_POW2;
        end
        base = 48'd1 << (SMALL_POW2 + oct);
        step = base >> BUCKET_POW2;
        sum  = base + step * 48'(j);
        return sum[SIZE_W-1:0];
    endfunction

endpackage

// ----- rtl/fbsc_ctrl.sv -----
// Controller state machine that sequences map, update, scan and result load.
`timescale 1ns / 1ps

module fbsc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  fbsc_pkg::t_sts i_sts,
    output fbsc_pkg::t_cmd o_cmd,
    output logic           o_in_stall
);
    import fbsc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MAP;
                end
            end
            ST_MAP: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (i_sts.op == OP_LARGEST || (i_sts.op == OP_SEARCH && !i_sts.err)) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_SCAN: begin
                if (i_sts.found || i_sts.last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_in_stall     = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.load_in = i_in_valid;
            end
            ST_MAP: begin
                o_cmd.do_map = 1'b1;
            end
            ST_EXEC: begin
                o_cmd.do_exec = 1'b1;
            end
            ST_SCAN: begin
                o_cmd.do_scan = 1'b1;
            end
            ST_FIN: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ----- rtl/fbsc_dp.sv -----
// Datapath: size-to-class mapping, occupancy bitmap, word scanner and result register.
`timescale 1ns / 1ps

module fbsc_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fbsc_pkg::t_cmd                i_cmd,
    output fbsc_pkg::t_sts                o_sts,
    input  logic [1:0]                    i_opcode,
    input  logic [fbsc_pkg::SIZE_W-1:0]   i_block_size,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [fbsc_pkg::CLS_W-1:0]    o_class_index,
    output logic [fbsc_pkg::SIZE_W-1:0]   o_class_base_size,
    output logic                          o_class_occupied,
    output logic                          o_next_found,
    output logic [fbsc_pkg::CLS_W-1:0]    o_next_index,
    output logic [fbsc_pkg::SIZE_W-1:0]   o_next_base_size,
    output logic                          o_size_error
);
    import fbsc_pkg::*;

    // Captured request.
    t_op               r_op;
    logic [SIZE_W-1:0] r_size;

    // Mapping results.
    logic [CLS_W-1:0]  r_cls;
    logic              r_err;
    logic [SIZE_W-1:0] r_cls_base;
    logic              r_cls_occ;

    // Scan state.
    logic [WIDX_W-1:0] r_ptr;
    logic              r_first;
    logic              r_next_found;
    logic [CLS_W-1:0]  r_next_idx;

    logic [31:0]       r_bitmap [LIM_WORDS];
    logic              r_out_valid;
    logic              n_out_valid;

    // Size to class mapping.
    logic [POS_W-1:0]      p;
    logic [SIZE_W-1:0]     sz_shr;
    logic [SIZE_W-1:0]     bkt;
    logic [CLS_WIDE_W-1:0] cls_wide;
    logic                  too_small;
    logic                  too_big;
    logic                  map_err;

    always_comb begin
        p = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (r_size[i]) begin
                p = POS_W'(i);
            end
        end
        sz_shr    = r_size >> (int'(p) - BUCKET_POW2);
        bkt       = sz_shr & SIZE_W'(BKT_MASK);
        too_small = r_size < SIZE_W'(MIN_BLOCK);
        too_big   = (32'(r_size) >> MAX_POW) != 32'd0;
        if (r_size < SIZE_W'(2 ** SMALL_POW2)) begin
            cls_wide = CLS_WIDE_W'((r_size - SIZE_W'(MIN_BLOCK)) >> 2);
        end else begin
            cls_wide = CLS_WIDE_W'(SMALL_COUNT)
                     + CLS_WIDE_W'((int'(p) - SMALL_POW2) << BUCKET_POW2)
                     + CLS_WIDE_W'(bkt);
        end
        map_err = too_small || too_big || (cls_wide >= CLS_WIDE_W'(CLASS_LIMIT));
    end

    // Word scanner.
    logic [WIDX_W-1:0] cls_word;
    logic [31:0]       scan_word;
    logic [31:0]       scan_mask;
    logic [31:0]       masked;
    logic [4:0]        hi_pos;
    logic [4:0]        lo_pos;
    logic [4:0]        scan_off;
    logic              scan_found;
    logic              scan_last;
    logic              is_search;

    assign cls_word  = WIDX_W'(r_cls >> 5);
    assign is_search = (r_op == OP_SEARCH);

    always_comb begin
        scan_word = r_bitmap[r_ptr];
        if (is_search && r_first) begin
            scan_mask = (32'd1 << (5'd31 - r_cls[4:0])) - 32'd1;
        end else begin
            scan_mask = '1;
        end
        masked = scan_word & scan_mask;
        hi_pos = '0;
        for (int i = 0; i < 32; i++) begin
            if (masked[i]) begin
                hi_pos = 5'(i);
            end
        end
        lo_pos = '0;
        for (int i = 31; i >= 0; i--) begin
            if (masked[i]) begin
                lo_pos = 5'(i);
            end
        end
        scan_off   = is_search ? (5'd31 - hi_pos) : (5'd31 - lo_pos);
        scan_found = |masked;
        scan_last  = is_search ? (r_ptr == WIDX_W'(LIM_WORDS - 1)) : (r_ptr == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= t_op'(i_opcode);
            r_size <= i_block_size;
        end
        if (i_cmd.do_map) begin
            r_cls <= CLS_W'(cls_wide);
            r_err <= map_err;
        end
        if (i_cmd.do_exec) begin
            r_cls_base   <= class_base(r_cls);
            r_next_found <= 1'b0;
            r_next_idx   <= '0;
            r_first      <= 1'b1;
            if (r_op == OP_MARK_SET) begin
                r_cls_occ <= 1'b1;
            end else if (r_op == OP_MARK_CLR) begin
                r_cls_occ <= 1'b0;
            end else begin
                r_cls_occ <= r_bitmap[cls_word][5'd31 - r_cls[4:0]];
            end
            if (r_op == OP_LARGEST) begin
                r_ptr <= WIDX_W'(LIM_WORDS - 1);
            end else begin
                r_ptr <= cls_word;
            end
        end
        if (i_cmd.do_scan) begin
            r_first <= 1'b0;
            if (scan_found) begin
                r_next_found <= 1'b1;
                r_next_idx   <= CLS_W'(int'(r_ptr) * 32 + int'(scan_off));
            end else if (!scan_last) begin
                r_ptr <= is_search ? (r_ptr + 1'b1) : (r_ptr - 1'b1);
            end
        end
        if (i_cmd.load_out) begin
            if (r_op == OP_LARGEST) begin
                o_class_index     <= '0;
                o_class_base_size <= '0;
                o_class_occupied  <= 1'b0;
                o_size_error      <= 1'b0;
            end else begin
                o_class_index     <= r_err ? '0 : r_cls;
                o_class_base_size <= r_err ? '0 : r_cls_base;
                o_class_occupied  <= r_err ? 1'b0 : r_cls_occ;
                o_size_error      <= r_err;
            end
            if (r_next_found && (r_op == OP_LARGEST || (is_search && !r_err))) begin
                o_next_found     <= 1'b1;
                o_next_index     <= r_next_idx;
                o_next_base_size <= class_base(r_next_idx);
            end else begin
                o_next_found     <= 1'b0;
                o_next_index     <= '0;
                o_next_base_size <= '0;
            end
        end
    end

    // Occupancy bitmap; class c lives in bit 31 - (c mod 32) of word c / 32.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < LIM_WORDS; w++) begin
                r_bitmap[w] <= '0;
            end
        end else if (i_cmd.do_exec && !r_err &&
                     (r_op == OP_MARK_SET || r_op == OP_MARK_CLR)) begin
            r_bitmap[cls_word][5'd31 - r_cls[4:0]] <= (r_op == OP_MARK_SET);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sts.op       = r_op;
    assign o_sts.err      = r_err;
    assign o_sts.found    = scan_found;
    assign o_sts.last     = scan_last;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

endmodule

// ----- rtl/free_block_size_class_bitmap.sv -----
// Top level of the size-class occupancy bitmap: controller plus datapath.
`timescale 1ns / 1ps
// A mark or a size error passes through the map, update and result-load states; a search or a
// largest query also passes through the scan state, which visits 1 to 4 bitmap words, one word
// per cycle through a single read port, until a set bit is found or the last word is scanned.
// One item is taken at a time: a new transfer waits until the last result is loaded for output.
// Reset is synchronous and active low; it clears the controller and marks every class empty.

module free_block_size_class_bitmap (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_opcode,
    input  logic [fbsc_pkg::SIZE_W-1:0]   i_block_size,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [fbsc_pkg::CLS_W-1:0]    o_class_index,
    output logic [fbsc_pkg::SIZE_W-1:0]   o_class_base_size,
    output logic                          o_class_occupied,
    output logic                          o_next_found,
    output logic [fbsc_pkg::CLS_W-1:0]    o_next_index,
    output logic [fbsc_pkg::SIZE_W-1:0]   o_next_base_size,
    output logic                          o_size_error
);
    import fbsc_pkg::*;

    // The controller only steps through states; all payload lives in the datapath.
    t_cmd cmd;
    t_sts sts;

    fbsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath keeps the result in an output register, so a new transfer can be
    // taken while the previous result still waits on a stalled receiver.
    fbsc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_opcode          (i_opcode),
        .i_block_size      (i_block_size),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_class_index     (o_class_index),
        .o_class_base_size (o_class_base_size),
        .o_class_occupied  (o_class_occupied),
        .o_next_found      (o_next_found),
        .o_next_index      (o_next_index),
        .o_next_base_size  (o_next_base_size),
        .o_size_error      (o_size_error)
    );

endmodule

// ----- rtl/fbsc_chk.sv -----
// Port-level checker for the size-class bitmap and its bind to the top level.
`timescale 1ns / 1ps

module fbsc_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [fbsc_pkg::CLS_W-1:0]    o_class_index,
    input logic [fbsc_pkg::SIZE_W-1:0]   o_class_base_size,
    input logic                          o_class_occupied,
    input logic                          o_next_found,
    input logic [fbsc_pkg::CLS_W-1:0]    o_next_index,
    input logic [fbsc_pkg::SIZE_W-1:0]   o_next_base_size,
    input logic                          o_size_error
);

    // A result that is held back stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A held result keeps its payload; the occupied flag is not part of this check.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_class_index) && $stable(o_next_index)
            && $stable(o_class_base_size) && $stable(o_next_base_size)
            && $stable(o_size_error) && $stable(o_next_found))
        else $error("result payload changed while stalled");

    // One item at a time: an input transfer is followed by a busy cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transfer taken while busy");

    // A size error clears every other field.
    a_err_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_size_error |-> o_class_index == '0 && o_class_base_size == '0
            && !o_class_occupied && !o_next_found && o_next_index == '0
            && o_next_base_size == '0)
        else $error("fields set alongside a size error");

    // Without a next class, its fields are zero.
    a_next_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_next_found |-> o_next_index == '0 && o_next_base_size == '0)
        else $error("next class fields set without a hit");

endmodule

bind free_block_size_class_bitmap fbsc_chk u_fbsc_chk (.*);
